// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, request codes and helper functions of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int PG_W = 16;

  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_FILL   = 3'd1;
  localparam logic [2:0] REQ_RFREE  = 3'd2;
  localparam logic [2:0] REQ_RBUSY  = 3'd3;
  localparam logic [2:0] REQ_ALLOC  = 3'd4;
  localparam logic [2:0] REQ_FREE   = 3'd5;
  localparam logic [2:0] REQ_STATUS = 3'd6;

  localparam logic [3:0] CFG_TOTAL = 4'd0;
  localparam logic [3:0] CFG_BASE  = 4'd1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CLR  = 5'b00010,
    ST_CALC = 5'b00100,
    ST_WALK = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  typedef struct packed {
    logic            vld;
    logic            empty;
    logic [PG_W-1:0] first;
    logic [PG_W-1:0] last;
  } range_t;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      n = n + {5'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Bitmap physical page allocator with a used count, driven by request stream.
// ----------------------------------------------------------------------------
// Requests enter on in_ (kind in in_tuser, addr and length in in_tdata), one
// response per request leaves on out_. Registers total_pages and mem_base are
// written through cfg_; the user must do so only while the block is idle (the block does not enforce it).
// Requests are served one at a time; in_tready is high only when idle.
// Status and unknown kinds go straight to the response. Range and single-page
// free requests first pass the address arithmetic of bpa_range_calc, then walk
// the map one 32-bit word per cycle through the read port of the map memory.
// Fill and alloc walk from word 0 (alloc stops at the first free page).
// Clear-all sweeps every map word, one per cycle. After reset the same sweep
// runs before the first request is taken; config writes are taken throughout.
// A stalled receiver holds the response in the output register; a finished
// request then waits before its response is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // addr, length
  input  wire logic [2:0]  in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [87:0] out_tdata,  // ok, page_addr, used_pages, free_pages, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  localparam int WORDS = (MAX_PAGES + 31) / 32;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SH    = $clog2(PAGE_BYTES);
  localparam logic [WA_W-1:0] LAST_W = WA_W'(WORDS - 1);
  localparam logic [20:0]     MAXP   = 21'(MAX_PAGES);

  function automatic logic [WA_W-1:0] word_of(input logic [PG_W-1:0] p);
    logic [31:0] t;
    t = {16'd0, p} >> 5;
    return t[WA_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [15:0] total_r;
  logic [47:0] base_r;
  logic [15:0] used_r, used_nxt;
  logic        ok_r, ok_nxt;
  logic [47:0] pa_r, pa_nxt;
  logic        busy_r, busy_nxt, alloc_r, alloc_nxt;
  logic        fill_r, fill_nxt;
  logic        boot_r, boot_nxt;
  logic [WA_W-1:0] clr_w_r, clr_w_nxt;
  logic [WA_W:0]   rd_w_r, rd_w_nxt;
  logic [WA_W-1:0] fw_r, fw_nxt, lw_r, lw_nxt, pw_r, pw_nxt;
  logic [PG_W-1:0] fp_r, fp_nxt, lm1_r, lm1_nxt;
  logic        pv_r, pv_nxt;
  logic        out_valid_r;
  logic [87:0] out_data_r;

  logic [PG_W-1:0] tot;
  logic [20:0]     tot21;
  logic            in_acc;
  logic            calc_start;
  logic [47:0]     calc_len;
  range_t          rng;

  logic            we;
  logic [WA_W-1:0] waddr, raddr;
  logic [31:0]     wdata, rdata;

  logic [4:0]  lo5, hi5;
  logic [31:0] mask, freeb;
  logic [5:0]  flips;
  logic [16:0] upsum;
  logic [4:0]  idx;
  logic [WA_W+4:0] apage;
  logic [15:0] freep;

  assign tot21 = ({5'd0, total_r} < MAXP) ? {5'd0, total_r} : MAXP;
  assign tot   = tot21[PG_W-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign calc_start = in_acc && ((in_tuser == REQ_RFREE) || (in_tuser == REQ_RBUSY) ||
                                 (in_tuser == REQ_FREE));
  assign calc_len   = (in_tuser == REQ_FREE) ? 48'd1 : in_tdata[95:48];

  bpa_range_calc #(.PAGE_BYTES(PAGE_BYTES)) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (calc_start),
    .base     (in_tdata[47:0]),
    .len      (calc_len),
    .mem_base (base_r),
    .tot      (tot),
    .rng      (rng)
  );

  bpa_map_ram #(.DEPTH(WORDS), .AW(WA_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // per-word mask of the page interval
  always_comb begin
    lo5   = (pw_r == fw_r) ? fp_r[4:0] : 5'd0;
    hi5   = (pw_r == lw_r) ? lm1_r[4:0] : 5'd31;
    mask  = ({32{1'b1}} << lo5) & ({32{1'b1}} >> (5'd31 - hi5));
    freeb = ~rdata & mask;
    flips = busy_r ? pop32(freeb) : pop32(rdata & mask);
    upsum = {1'b0, used_r} + {11'd0, flips};
    idx   = lowest_set(freeb);
    apage = {pw_r, idx};
    freep = (tot > used_r) ? (tot - used_r) : 16'd0;
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    ok_nxt    = ok_r;
    pa_nxt    = pa_r;
    busy_nxt  = busy_r;
    alloc_nxt = alloc_r;
    fill_nxt  = fill_r;
    boot_nxt  = boot_r;
    clr_w_nxt = clr_w_r;
    rd_w_nxt  = rd_w_r;
    fw_nxt    = fw_r;
    lw_nxt    = lw_r;
    pw_nxt    = pw_r;
    fp_nxt    = fp_r;
    lm1_nxt   = lm1_r;
    pv_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = pw_r;
    wdata     = 32'd0;
    raddr     = rd_w_r[WA_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ok_nxt    = 1'b1;
          pa_nxt    = 48'd0;
          busy_nxt  = (in_tuser == REQ_RBUSY) || (in_tuser == REQ_FILL) ||
                      (in_tuser == REQ_ALLOC);
          alloc_nxt = (in_tuser == REQ_ALLOC);
          fill_nxt  = (in_tuser == REQ_FILL);
          fp_nxt    = '0;
          lm1_nxt   = tot - 16'd1;
          fw_nxt    = '0;
          lw_nxt    = word_of(tot - 16'd1);
          rd_w_nxt  = '0;
          case (in_tuser)
            REQ_CLEAR: begin
              used_nxt  = 16'd0;
              clr_w_nxt = '0;
              state_nxt = ST_CLR;
            end
            REQ_FILL: begin
              used_nxt  = tot;
              state_nxt = (tot == 16'd0) ? ST_RESP : ST_WALK;
            end
            REQ_ALLOC: begin
              ok_nxt    = 1'b0;
              state_nxt = (tot == 16'd0) ? ST_RESP : ST_WALK;
            end
            REQ_RFREE, REQ_RBUSY, REQ_FREE: state_nxt = ST_CALC;
            REQ_STATUS: state_nxt = ST_RESP;
            default: begin
              ok_nxt    = 1'b0;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_CLR: begin
        we        = 1'b1;
        waddr     = clr_w_r;
        clr_w_nxt = clr_w_r + 1'b1;
        if (clr_w_r == LAST_W) begin
          // the sweep after reset answers nothing
          state_nxt = boot_r ? ST_IDLE : ST_RESP;
          boot_nxt  = 1'b0;
        end
      end
      ST_CALC: begin
        if (rng.vld) begin
          fp_nxt   = rng.first;
          lm1_nxt  = rng.last - 16'd1;
          fw_nxt   = word_of(rng.first);
          lw_nxt   = word_of(rng.last - 16'd1);
          rd_w_nxt = {1'b0, word_of(rng.first)};
          state_nxt = rng.empty ? ST_RESP : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_w_r <= {1'b0, lw_r}) begin
          pv_nxt   = 1'b1;
          pw_nxt   = rd_w_r[WA_W-1:0];
          rd_w_nxt = rd_w_r + 1'b1;
        end
        if (pv_r) begin
          if (alloc_r) begin
            if (freeb != 32'd0) begin
              we        = 1'b1;
              wdata     = rdata | (32'd1 << idx);
              used_nxt  = (used_r == 16'hFFFF) ? used_r : used_r + 16'd1;
              ok_nxt    = 1'b1;
              pa_nxt    = base_r + (48'(apage) << SH);
              pv_nxt    = 1'b0;
              state_nxt = ST_RESP;
            end
          end else begin
            we = 1'b1;
            if (busy_r) begin
              wdata = rdata | mask;
              // fill sets the count up front
              if (!fill_r) begin
                used_nxt = upsum[16] ? 16'hFFFF : upsum[15:0];
              end
            end else begin
              wdata    = rdata & ~mask;
              used_nxt = (used_r < {10'd0, flips}) ? 16'd0 : used_r - {10'd0, flips};
            end
          end
          if (pw_r == lw_r) begin
            pv_nxt    = 1'b0;
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_w_r     <= '0;
      boot_r      <= 1'b1;
      used_r      <= 16'd0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= 16'd32768;
      base_r      <= 48'h100000;
    end else begin
      state_r <= state_nxt;
      clr_w_r <= clr_w_nxt;
      boot_r  <= boot_nxt;
      used_r  <= used_nxt;
      pv_r    <= pv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOTAL) begin
          total_r <= cfg_data[15:0];
        end else if (cfg_index == CFG_BASE) begin
          base_r <= cfg_data;
        end
      end
      if (state_r == ST_RESP && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    ok_r    <= ok_nxt;
    pa_r    <= pa_nxt;
    busy_r  <= busy_nxt;
    alloc_r <= alloc_nxt;
    fill_r  <= fill_nxt;
    rd_w_r  <= rd_w_nxt;
    fw_r    <= fw_nxt;
    lw_r    <= lw_nxt;
    pw_r    <= pw_nxt;
    fp_r    <= fp_nxt;
    lm1_r   <= lm1_nxt;
    if (state_r == ST_RESP && (!out_valid_r || out_tready)) begin
      out_data_r <= {7'd0, freep, used_r, pa_r, ok_r};
    end
  end

endmodule

`default_nettype wire

// ===== src/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_map_ram
// Used-bit map storage, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bpa_range_calc.sv =====
// ----------------------------------------------------------------------------
// bpa_range_calc
// Three-stage conversion of a byte range to a clamped page interval.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_range_calc
  import bpa_pkg::*;
#(
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [47:0]     base,
  input  wire logic [47:0]     len,
  input  wire logic [47:0]     mem_base,
  input  wire logic [PG_W-1:0] tot,
  output range_t               rng
);

  localparam int          SH   = $clog2(PAGE_BYTES);
  localparam logic [49:0] PBM1 = 50'(PAGE_BYTES - 1);

  logic        v1_r, v2_r, v3_r;
  logic        e1_r, e2_r, e3_r;
  logic [47:0] cb_r, cl_r, offs_r;
  logic [48:0] offe_r;
  logic [PG_W-1:0] first_r, last_r;

  logic [47:0] skip;
  logic [47:0] fw;
  logic [49:0] lw;
  logic [PG_W-1:0] first_c, last_c;

  assign skip = mem_base - base;
  assign fw   = offs_r >> SH;
  assign lw   = ({1'b0, offe_r} + PBM1) >> SH;

  always_comb begin
    first_c = (fw >= {32'd0, tot}) ? tot : fw[PG_W-1:0];
    last_c  = (lw > {34'd0, tot}) ? tot : lw[PG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    // clip at the memory start
    if (base < mem_base) begin
      e1_r <= (len == 48'd0) || (skip >= len);
      cb_r <= mem_base;
      cl_r <= len - skip;
    end else begin
      e1_r <= (len == 48'd0);
      cb_r <= base;
      cl_r <= len;
    end
    e2_r    <= e1_r;
    offs_r  <= cb_r - mem_base;
    offe_r  <= {1'b0, cb_r} + {1'b0, cl_r} - {1'b0, mem_base};
    e3_r    <= e2_r || (first_c >= last_c);
    first_r <= first_c;
    last_r  <= last_c;
  end

  assign rng = '{vld: v3_r, empty: e3_r, first: first_r, last: last_r};

endmodule

`default_nettype wire

// ===== src/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled response changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[48:1] == 48'd0)
    else $error("failed request carries a page address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("response after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
